// File: src/lbpc_pkg.sv
// Shared constants for the LED blink pattern controller.
// No dependencies; imported by led_blink_pattern_controller.
`timescale 1ns / 1ps

package lbpc_pkg;

   localparam int NUM_LEDS_DEF  = 4;
   localparam int TIME_BITS_DEF = 16;

   localparam int IN_TIME_W  = 16;
   localparam int IDX_W      = 2;
   localparam int MODE_W     = 2;
   localparam int OUT_LEDS   = 4;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;

   localparam logic [IN_TIME_W-1:0] FLOOR_TICKS_RST = 16'd50;

   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BSTOP = 2'd3;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_SET  = 1'b1;

endpackage

// File: src/led_blink_pattern_controller.sv
// An accepted request waits in the request register and moves into the response
// register once that register is empty or its response is taken. Throughput:
// one request per cycle unless rsp_tready stalls, with the per-LED timer update
// and one 17x16 burst-length multiply between the request and response
// registers. Reset (synchronous, active high) clears all LED state and timers,
// sets the blink floor to 50 and empties both registers. Depends on lbpc_pkg.
`timescale 1ns / 1ps

module led_blink_pattern_controller #(
   parameter int NUM_LEDS  = lbpc_pkg::NUM_LEDS_DEF,
   parameter int TIME_BITS = lbpc_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // led_index[1:0], mode[3:2], on_time[19:4], off_time[35:20],
   // cycle_total[51:36], pause_time[67:52], zero pad [71:68]
   input  logic [lbpc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func[0]
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // led_levels[3:0], blink_mask[7:4]
   output logic [lbpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lbpc_pkg::IN_TIME_W-1:0]    csr_data
);
   import lbpc_pkg::*;

   localparam int PHASE_BITS = TIME_BITS + 1 + IN_TIME_W;
   localparam int SAT_W      = IN_TIME_W + TIME_BITS;
   localparam logic [SAT_W-1:0] TIME_MAX = SAT_W'((64'd1 << TIME_BITS) - 64'd1);

   function automatic logic [TIME_BITS-1:0] sat_time(input logic [IN_TIME_W-1:0] v);
      logic [SAT_W-1:0] ext;
      ext = SAT_W'(v);
      return (ext > TIME_MAX) ? TIME_BITS'(TIME_MAX) : ext[TIME_BITS-1:0];
   endfunction

   // request register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_func_ff;
   logic [IDX_W-1:0]      in_idx_ff;
   logic [MODE_W-1:0]     in_mode_ff;
   logic [IN_TIME_W-1:0]  in_on_ff, in_off_ff, in_cyc_ff, in_pause_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_LEDS-1:0]   rsp_levels_ff, rsp_levels_in;
   logic [OUT_LEDS-1:0]   rsp_mask_ff, rsp_mask_in;

   logic [IN_TIME_W-1:0]  floor_ticks_ff;

   // per-LED state
   logic [MODE_W-1:0]     mode_ff [NUM_LEDS];
   logic [MODE_W-1:0]     mode_in [NUM_LEDS];
   logic [NUM_LEDS-1:0]   lit_ff, lit_in;
   logic [NUM_LEDS-1:0]   saved_ff, saved_in;
   logic [NUM_LEDS-1:0]   paused_ff, paused_in;
   logic [NUM_LEDS-1:0]   blink_armed_ff, blink_armed_in;
   logic [NUM_LEDS-1:0]   phase_armed_ff, phase_armed_in;
   logic [TIME_BITS-1:0]  on_ticks_ff [NUM_LEDS];
   logic [TIME_BITS-1:0]  on_ticks_in [NUM_LEDS];
   logic [TIME_BITS-1:0]  off_ticks_ff [NUM_LEDS];
   logic [TIME_BITS-1:0]  off_ticks_in [NUM_LEDS];
   logic [TIME_BITS-1:0]  pause_ticks_ff [NUM_LEDS];
   logic [TIME_BITS-1:0]  pause_ticks_in [NUM_LEDS];
   logic [TIME_BITS-1:0]  blink_rem_ff [NUM_LEDS];
   logic [TIME_BITS-1:0]  blink_rem_in [NUM_LEDS];
   logic [PHASE_BITS-1:0] burst_ff [NUM_LEDS];
   logic [PHASE_BITS-1:0] burst_in [NUM_LEDS];
   logic [PHASE_BITS-1:0] phase_rem_ff [NUM_LEDS];
   logic [PHASE_BITS-1:0] phase_rem_in [NUM_LEDS];

   logic                  advance;
   logic [NUM_LEDS-1:0]   blink_mode_vec;

   // shared command arithmetic
   logic [TIME_BITS-1:0]  cmd_on_s, cmd_off_s, cmd_pz, cmd_mi, cmd_on_c, cmd_off_c;
   logic [TIME_BITS:0]    cmd_sum;
   logic [PHASE_BITS-1:0] cmd_burst;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_mask_ff, rsp_levels_ff};

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      cmd_on_s  = sat_time(in_on_ff);
      cmd_off_s = sat_time(in_off_ff);
      cmd_pz    = sat_time(in_pause_ff);
      cmd_mi    = sat_time(floor_ticks_ff);
      cmd_on_c  = (cmd_on_s < cmd_mi) ? cmd_mi : cmd_on_s;
      cmd_off_c = (cmd_off_s < cmd_mi) ? cmd_mi : cmd_off_s;
      cmd_sum   = {1'b0, cmd_on_c} + {1'b0, cmd_off_c};
      cmd_burst = PHASE_BITS'(cmd_sum) * PHASE_BITS'(in_cyc_ff);
   end

   always_comb begin
      logic bf;
      logic pf;
      logic [TIME_BITS-1:0] t;
      lit_in         = lit_ff;
      saved_in       = saved_ff;
      paused_in      = paused_ff;
      blink_armed_in = blink_armed_ff;
      phase_armed_in = phase_armed_ff;
      bf             = 1'b0;
      pf             = 1'b0;
      t              = '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
         mode_in[i]        = mode_ff[i];
         on_ticks_in[i]    = on_ticks_ff[i];
         off_ticks_in[i]   = off_ticks_ff[i];
         pause_ticks_in[i] = pause_ticks_ff[i];
         blink_rem_in[i]   = blink_rem_ff[i];
         burst_in[i]       = burst_ff[i];
         phase_rem_in[i]   = phase_rem_ff[i];
         if (advance && in_func_ff == FUNC_TICK) begin
            bf = 1'b0;
            pf = 1'b0;
            if (blink_armed_ff[i]) begin
               if (blink_rem_ff[i] <= TIME_BITS'(1)) begin
                  blink_rem_in[i]   = '0;
                  bf                = 1'b1;
                  blink_armed_in[i] = 1'b0;
               end else begin
                  blink_rem_in[i] = blink_rem_ff[i] - TIME_BITS'(1);
               end
            end
            if (phase_armed_ff[i]) begin
               if (phase_rem_ff[i] <= PHASE_BITS'(1)) begin
                  phase_rem_in[i] = '0;
                  pf              = 1'b1;
               end else begin
                  phase_rem_in[i] = phase_rem_ff[i] - PHASE_BITS'(1);
               end
            end
            if (pf) begin
               phase_armed_in[i] = 1'b0;
               if (mode_ff[i] == MODE_BLINK) begin
                  blink_armed_in[i] = 1'b0;
                  bf                = 1'b0;
                  lit_in[i]         = saved_ff[i];
               end else if (mode_ff[i] == MODE_BSTOP) begin
                  paused_in[i] = !paused_ff[i];
                  bf           = 1'b0;
                  if (!paused_ff[i]) begin
                     blink_armed_in[i] = 1'b0;
                     lit_in[i]         = saved_ff[i];
                     phase_armed_in[i] = 1'b1;
                     phase_rem_in[i]   = PHASE_BITS'(pause_ticks_ff[i]);
                  end else begin
                     phase_armed_in[i] = 1'b1;
                     phase_rem_in[i]   = burst_ff[i];
                     blink_armed_in[i] = 1'b1;
                     blink_rem_in[i]   = '0;
                  end
               end
            end
            if (bf) begin
               unique case (mode_ff[i])
                  MODE_ON: begin
                     if (on_ticks_ff[i] != '0) lit_in[i] = 1'b0;
                  end
                  MODE_OFF: begin
                     if (off_ticks_ff[i] != '0) lit_in[i] = 1'b1;
                  end
                  default: begin
                     lit_in[i]         = !lit_ff[i];
                     blink_armed_in[i] = 1'b1;
                     blink_rem_in[i]   = lit_ff[i] ? off_ticks_ff[i] : on_ticks_ff[i];
                  end
               endcase
            end
         end else if (advance && int'(in_idx_ff) == i) begin
            priority if (in_mode_ff == MODE_OFF || in_mode_ff == MODE_ON) begin
               t                 = (in_mode_ff == MODE_OFF) ? cmd_off_s : cmd_on_s;
               phase_armed_in[i] = 1'b0;
               if (t != '0) begin
                  if (in_mode_ff == MODE_OFF) off_ticks_in[i] = t;
                  else on_ticks_in[i] = t;
                  blink_armed_in[i] = 1'b1;
                  blink_rem_in[i]   = t;
               end else begin
                  blink_armed_in[i] = 1'b0;
               end
               mode_in[i] = in_mode_ff;
               lit_in[i]  = (in_mode_ff == MODE_ON);
            end else if (in_mode_ff == MODE_BSTOP && (in_cyc_ff == '0 || cmd_pz == '0)) begin
               phase_armed_in[i] = 1'b0;
            end else begin
               mode_in[i]      = in_mode_ff;
               saved_in[i]     = lit_ff[i];
               on_ticks_in[i]  = cmd_on_c;
               off_ticks_in[i] = cmd_off_c;
               burst_in[i]     = cmd_burst;
               if (in_mode_ff == MODE_BLINK) begin
                  pause_ticks_in[i] = '0;
                  phase_armed_in[i] = (in_cyc_ff != '0);
               end else begin
                  pause_ticks_in[i] = cmd_pz;
                  paused_in[i]      = 1'b0;
                  phase_armed_in[i] = 1'b1;
               end
               phase_rem_in[i]   = cmd_burst;
               blink_armed_in[i] = 1'b1;
               blink_rem_in[i]   = '0;
            end
         end
      end
      rsp_levels_in = advance ? OUT_LEDS'(lit_in) : rsp_levels_ff;
      rsp_mask_in   = advance ? OUT_LEDS'(blink_armed_in) : rsp_mask_ff;
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_func_ff  <= req_tuser[0];
         in_idx_ff   <= req_tdata[1:0];
         in_mode_ff  <= req_tdata[3:2];
         in_on_ff    <= req_tdata[19:4];
         in_off_ff   <= req_tdata[35:20];
         in_cyc_ff   <= req_tdata[51:36];
         in_pause_ff <= req_tdata[67:52];
      end
      rsp_levels_ff <= rsp_levels_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         floor_ticks_ff  <= FLOOR_TICKS_RST;
         lit_ff          <= '0;
         saved_ff        <= '0;
         paused_ff       <= '0;
         blink_armed_ff  <= '0;
         phase_armed_ff  <= '0;
         for (int i = 0; i < NUM_LEDS; i++) begin
            mode_ff[i]        <= MODE_OFF;
            on_ticks_ff[i]    <= '0;
            off_ticks_ff[i]   <= '0;
            pause_ticks_ff[i] <= '0;
            blink_rem_ff[i]   <= '0;
            burst_ff[i]       <= '0;
            phase_rem_ff[i]   <= '0;
         end
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) floor_ticks_ff <= csr_data;
         lit_ff         <= lit_in;
         saved_ff       <= saved_in;
         paused_ff      <= paused_in;
         blink_armed_ff <= blink_armed_in;
         phase_armed_ff <= phase_armed_in;
         for (int i = 0; i < NUM_LEDS; i++) begin
            mode_ff[i]        <= mode_in[i];
            on_ticks_ff[i]    <= on_ticks_in[i];
            off_ticks_ff[i]   <= off_ticks_in[i];
            pause_ticks_ff[i] <= pause_ticks_in[i];
            blink_rem_ff[i]   <= blink_rem_in[i];
            burst_ff[i]       <= burst_in[i];
            phase_rem_ff[i]   <= phase_rem_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_LEDS; i++) begin
         blink_mode_vec[i] = mode_ff[i][1];
      end
   end

`ifndef SYNTHESIS
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while the request register is stalled");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed request produced no response");

   a_phase_only_blink: assert property (@(posedge clock) disable iff (reset)
      (phase_armed_ff & ~blink_mode_vec) == '0)
      else $error("phase timer armed outside the blink modes");

   a_unused_leds_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[3:0] | rsp_tdata[7:4]) >> NUM_LEDS) == '0)
      else $error("response shows a LED that does not exist");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking bench for led_blink_pattern_controller: directed rows, then random
// ticks and LED commands under a changing blink floor and handshake pressure.
// Depends on lbpc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_top;
   import lbpc_pkg::*;

   localparam int NLED           = OUT_LEDS;
   localparam int DUT_LATENCY    = 2;
   localparam int SETTLE_CYCLES  = DUT_LATENCY + 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES     = 5;
   localparam bit [15:0] TMAX    = 16'hFFFF;

   typedef struct packed {
      logic                 func;
      logic [IDX_W-1:0]     led_index;
      logic [MODE_W-1:0]    mode;
      logic [IN_TIME_W-1:0] on_time;
      logic [IN_TIME_W-1:0] off_time;
      logic [IN_TIME_W-1:0] cycle_total;
      logic [IN_TIME_W-1:0] pause_time;
   } lamp_req_type;

   typedef struct packed {
      logic [3:0] blink_mask;
      logic [3:0] led_levels;
   } lamp_rsp_type;

   typedef struct packed {
      lamp_req_type req;
      logic         typed;
      logic [3:0]   want_levels;
      logic [3:0]   want_mask;
   } opening_row_type;

   localparam int NUM_ROWS = 21;
   localparam opening_row_type OPENING_ROWS [NUM_ROWS] = '{
      '{'{FUNC_TICK, 2'd0, MODE_OFF,   16'd0,   16'd0,   16'd0, 16'd0},   1'b1, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd0, MODE_ON,    16'd0,   16'd0,   16'd0, 16'd0},   1'b1, 4'h1, 4'h0},
      '{'{FUNC_SET,  2'd1, MODE_OFF,   TMAX,    16'd0,   16'd0, 16'd0},   1'b1, 4'h1, 4'h0},
      '{'{FUNC_SET,  2'd2, MODE_ON,    16'd1,   16'd0,   16'd0, 16'd0},   1'b1, 4'h5, 4'h4},
      '{'{FUNC_TICK, 2'd0, MODE_OFF,   16'd0,   16'd0,   16'd0, 16'd0},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd3, MODE_OFF,   16'd0,   TMAX,    16'd0, 16'd0},   1'b1, 4'h1, 4'h8},
      '{'{FUNC_SET,  2'd1, MODE_BLINK, 16'd0,   16'd0,   16'd2, 16'd9},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_TICK, 2'd0, MODE_OFF,   16'd0,   16'd0,   16'd0, 16'd0},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd2, MODE_BSTOP, 16'd3,   16'd3,   16'd0, 16'd5},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd2, MODE_BSTOP, 16'd3,   16'd3,   16'd3, 16'd0},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd2, MODE_BSTOP, TMAX,    TMAX,    TMAX,  TMAX},    1'b0, 4'h0, 4'h0},
      '{'{FUNC_TICK, 2'd3, MODE_BSTOP, TMAX,    TMAX,    TMAX,  TMAX},    1'b0, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd0, MODE_BLINK, 16'd100, 16'd60,  16'd0, TMAX},    1'b0, 4'h0, 4'h0},
      '{'{FUNC_TICK, 2'd0, MODE_OFF,   16'd0,   16'd0,   16'd0, 16'd0},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_TICK, 2'd0, MODE_OFF,   16'd0,   16'd0,   16'd0, 16'd0},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd3, MODE_ON,    TMAX,    16'd0,   16'd0, 16'd0},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd0, MODE_OFF,   TMAX,    16'd0,   TMAX,  TMAX},    1'b0, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd1, MODE_OFF,   16'd0,   16'd7,   16'd0, 16'd0},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_SET,  2'd3, MODE_BLINK, 16'd1,   16'd1,   16'd1, TMAX},    1'b0, 4'h0, 4'h0},
      '{'{FUNC_TICK, 2'd0, MODE_OFF,   16'd0,   16'd0,   16'd0, 16'd0},   1'b0, 4'h0, 4'h0},
      '{'{FUNC_TICK, 2'd0, MODE_OFF,   16'd0,   16'd0,   16'd0, 16'd0},   1'b0, 4'h0, 4'h0}
   };

   localparam bit [15:0] PHASE_GAP   [NUM_PHASES] = '{16'd0, 16'd1, 16'd3, 16'd2, TMAX};
   localparam int        PHASE_SEND  [NUM_PHASES] = '{0, 56, 0, 29, 0};
   localparam int        PHASE_RECV  [NUM_PHASES] = '{0, 0, 56, 29, 0};
   localparam int        PHASE_ITEMS [NUM_PHASES] = '{110, 100, 100, 110, 60};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [IN_TIME_W-1:0]  csr_data   = '0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int errors         = 0;
   int quiet_cycles   = 0;

   lamp_rsp_type expected_levels [$];

   // lamp state tracked by the predictor
   logic [15:0] min_gap = FLOOR_TICKS_RST;
   logic [1:0]  lamp_mode   [NLED] = '{default: '0};
   logic        lit_q       [NLED] = '{default: '0};
   logic        saved_q     [NLED] = '{default: '0};
   logic        paused_q    [NLED] = '{default: '0};
   logic [15:0] on_q        [NLED] = '{default: '0};
   logic [15:0] off_q       [NLED] = '{default: '0};
   logic [15:0] pause_q     [NLED] = '{default: '0};
   logic [15:0] cycles_q    [NLED] = '{default: '0};
   logic [15:0] blink_cnt   [NLED] = '{default: '0};
   logic        blink_on    [NLED] = '{default: '0};
   logic [32:0] phase_cnt   [NLED] = '{default: '0};
   logic        phase_on    [NLED] = '{default: '0};

   led_blink_pattern_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [32:0] burst_length(int i);
      logic [32:0] span;
      span = {17'd0, on_q[i]} + {17'd0, off_q[i]};
      return span * {17'd0, cycles_q[i]};
   endfunction

   function automatic void apply_command(lamp_req_type r);
      int          i;
      logic [15:0] t;
      logic [15:0] on_t;
      logic [15:0] off_t;
      i     = int'(r.led_index);
      on_t  = r.on_time;
      off_t = r.off_time;
      if (r.mode == MODE_OFF || r.mode == MODE_ON) begin
         t = (r.mode == MODE_OFF) ? off_t : on_t;
         phase_on[i] = 1'b0;
         if (t != 0) begin
            if (r.mode == MODE_OFF) off_q[i] = t;
            else on_q[i] = t;
            blink_on[i]  = 1'b1;
            blink_cnt[i] = t;
         end else begin
            blink_on[i] = 1'b0;
         end
         lamp_mode[i] = r.mode;
         lit_q[i]     = (r.mode == MODE_ON);
      end else if (r.mode == MODE_BSTOP && (r.cycle_total == 0 || r.pause_time == 0)) begin
         phase_on[i] = 1'b0;
      end else begin
         if (on_t < min_gap) on_t = min_gap;
         if (off_t < min_gap) off_t = min_gap;
         lamp_mode[i] = r.mode;
         saved_q[i]   = lit_q[i];
         cycles_q[i]  = r.cycle_total;
         on_q[i]      = on_t;
         off_q[i]     = off_t;
         if (r.mode == MODE_BLINK) begin
            pause_q[i]  = '0;
            phase_on[i] = (r.cycle_total != 0);
            if (r.cycle_total != 0) phase_cnt[i] = burst_length(i);
         end else begin
            pause_q[i]   = r.pause_time;
            paused_q[i]  = 1'b0;
            phase_on[i]  = 1'b1;
            phase_cnt[i] = burst_length(i);
         end
         blink_on[i]  = 1'b1;
         blink_cnt[i] = '0;
      end
   endfunction

   function automatic void tick_lamp(int i);
      logic bfire;
      logic pfire;
      bfire = blink_on[i] && (blink_cnt[i] <= 1);
      pfire = phase_on[i] && (phase_cnt[i] <= 1);
      if (blink_on[i]) blink_cnt[i] = bfire ? 16'd0 : blink_cnt[i] - 16'd1;
      if (phase_on[i]) phase_cnt[i] = pfire ? 33'd0 : phase_cnt[i] - 33'd1;
      if (bfire) blink_on[i] = 1'b0;
      if (pfire) begin
         phase_on[i] = 1'b0;
         if (lamp_mode[i] == MODE_BLINK) begin
            blink_on[i] = 1'b0;
            bfire       = 1'b0;
            lit_q[i]    = saved_q[i];
         end else if (lamp_mode[i] == MODE_BSTOP) begin
            paused_q[i] = ~paused_q[i];
            bfire       = 1'b0;
            phase_on[i] = 1'b1;
            if (paused_q[i]) begin
               blink_on[i]  = 1'b0;
               lit_q[i]     = saved_q[i];
               phase_cnt[i] = {17'd0, pause_q[i]};
            end else begin
               phase_cnt[i] = burst_length(i);
               blink_on[i]  = 1'b1;
               blink_cnt[i] = '0;
            end
         end
      end
      if (bfire) begin
         if (lamp_mode[i] == MODE_ON) begin
            if (on_q[i] != 0) lit_q[i] = 1'b0;
         end else if (lamp_mode[i] == MODE_OFF) begin
            if (off_q[i] != 0) lit_q[i] = 1'b1;
         end else begin
            lit_q[i]     = ~lit_q[i];
            blink_on[i]  = 1'b1;
            blink_cnt[i] = lit_q[i] ? on_q[i] : off_q[i];
         end
      end
   endfunction

   function automatic lamp_rsp_type predict_levels(lamp_req_type r);
      lamp_rsp_type res;
      if (r.func == FUNC_TICK) begin
         for (int i = 0; i < NLED; i++) tick_lamp(i);
      end else begin
         apply_command(r);
      end
      for (int i = 0; i < NLED; i++) begin
         res.led_levels[i] = lit_q[i];
         res.blink_mask[i] = blink_on[i];
      end
      return res;
   endfunction

   function automatic logic [15:0] pick_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, 4));
      if (r < 80) return 16'($urandom_range(5, 40));
      if (r < 90) return TMAX;
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 16'($urandom_range(1, 3));
      if (r < 75) return 16'd0;
      if (r < 90) return 16'($urandom_range(4, 8));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic lamp_req_type random_request();
      lamp_req_type r;
      r.func        = ($urandom_range(0, 99) < 40) ? FUNC_SET : FUNC_TICK;
      r.led_index   = IDX_W'($urandom_range(0, 3));
      r.mode        = MODE_W'($urandom_range(0, 3));
      r.on_time     = pick_span();
      r.off_time    = pick_span();
      r.cycle_total = pick_count();
      r.pause_time  = pick_span();
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   task automatic send_request(lamp_req_type r, logic typed, lamp_rsp_type want);
      lamp_rsp_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.func;
      req_tdata  <= {4'd0, r.pause_time, r.cycle_total, r.off_time, r.on_time,
                     r.mode, r.led_index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_levels(r);
      expected_levels.push_back(typed ? want : pred);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_gap(logic [15:0] value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      min_gap = value;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      lamp_rsp_type got;
      lamp_rsp_type want;
      got = rsp_tdata;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch("unexpected response", int'(got), 0);
         end else begin
            want = expected_levels.pop_front();
            if (got.led_levels !== want.led_levels)
               report_mismatch("led_levels", int'(got.led_levels), int'(want.led_levels));
            if (got.blink_mask !== want.blink_mask)
               report_mismatch("blink_mask", int'(got.blink_mask), int'(want.blink_mask));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("led_blink_pattern_controller regression: fail");
         $finish;
      end
   end

   initial begin
      lamp_rsp_type want;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < NUM_ROWS; n++) begin
         want.led_levels = OPENING_ROWS[n].want_levels;
         want.blink_mask = OPENING_ROWS[n].want_mask;
         send_request(OPENING_ROWS[n].req, OPENING_ROWS[n].typed, want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_min_gap(PHASE_GAP[p]);
         send_idle_pct  = PHASE_SEND[p];
         recv_stall_pct = PHASE_RECV[p];
         for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
            // hold off until the pipeline is empty once
            if (p == 0 && k == PHASE_ITEMS[p] / 2) drain_responses();
            send_request(random_request(), 1'b0, '0);
         end
      end

      drain_responses();
      if (errors == 0)
         $display("led_blink_pattern_controller regression: pass");
      else
         $display("led_blink_pattern_controller regression: fail");
      $finish;
   end

endmodule

// File: led_blink_pattern_controller.f
src/lbpc_pkg.sv
src/led_blink_pattern_controller.sv
bench/tb_top.sv
